@@ rtl/hgpc_pkg.sv @@
// ----------------------------------------------------------------------------
// hgpc_pkg
// Shared types and constants of the holonomic goal P controller.
// ----------------------------------------------------------------------------
package hgpc_pkg;

  typedef enum logic [1:0] {
    REG_POS_TOL   = 2'd0,
    REG_HEAD_TOL  = 2'd1,
    REG_MAX_LIN   = 2'd2,
    REG_MAX_TURN  = 2'd3
  } reg_idx_e;

  localparam logic [15:0] HALF_TURN = 16'd11520;
  localparam logic [15:0] FULL_TURN = 16'd23040;
  localparam logic [14:0] TURN_15   = 15'd23040;
  localparam logic [14:0] QUARTER   = 15'd5760;
  localparam logic [14:0] EIGHTH    = 15'd2880;
  localparam logic [18:0] RAD_PER_U = 19'd292818;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

  localparam logic [32:0] TWO_32  = 33'h1_0000_0000;
  localparam logic [31:0] RCP_15  = 32'(TWO_32 / 15);
  localparam logic [31:0] RCP_42  = 32'(TWO_32 / 42);
  localparam logic [31:0] RCP_56  = 32'(TWO_32 / 56);
  localparam logic [31:0] RCP_20  = 32'(TWO_32 / 20);
  localparam logic [31:0] RCP_30  = 32'(TWO_32 / 30);
  localparam logic [31:0] RCP_6   = 32'(TWO_32 / 6);
  localparam logic [31:0] RCP_12  = 32'(TWO_32 / 12);

  typedef struct packed {
    logic [10:0] pos_tol;
    logic [13:0] head_tol;
    logic [14:0] max_lin;
    logic [14:0] max_turn;
  } cfg_t;

  typedef struct packed {
    logic        neg;
    logic [20:0] mag;
    logic        dead;
  } lin_err_t;

  typedef struct packed {
    logic        neg;
    logic [13:0] mag;
    logic        dead;
  } ang_err_t;

  typedef struct packed {
    lin_err_t    ex;
    lin_err_t    ey;
    ang_err_t    eh;
    logic [11:0] oct;
    logic        swap;
    logic [1:0]  quad;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // The reciprocal estimate is low by at most one; one compare fixes it.
  function automatic logic [31:0] quot_fix(input logic [31:0] v, input logic [31:0] q0,
                                           input logic [5:0] d);
    logic [31:0] r;
    r = v - q0 * 32'(d);
    return (r >= 32'(d)) ? q0 + 32'd1 : q0;
  endfunction

endpackage

@@ rtl/hgpc_front.sv @@
// ----------------------------------------------------------------------------
// hgpc_front
// Forms pose errors, heading wrap, deadband flags and the octant of the heading.
// ----------------------------------------------------------------------------
module hgpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [19:0]         target_x_i,
  input  logic [19:0]         target_y_i,
  input  logic [14:0]         target_heading_i,
  input  logic [19:0]         measured_x_i,
  input  logic [19:0]         measured_y_i,
  input  logic [14:0]         measured_heading_i,
  input  hgpc_pkg::cfg_t      cfg_i,
  input  hgpc_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output hgpc_pkg::item_t     item_o
);

  logic            f_v_q, f_v_d;
  hgpc_pkg::item_t f_q, f_d;
  logic            accept;

  logic [20:0]        dx, dy;
  logic signed [15:0] dth, dthw;
  logic [15:0]        hmag;
  logic [14:0]        ang, rem;
  logic [1:0]         quad;

  assign stall_o = f_v_q && q_stat_i.full;
  assign accept  = valid_i && !stall_o;
  assign push_o  = f_v_q && !q_stat_i.full;
  assign item_o  = f_q;

  always_comb begin
    dx  = {target_x_i[19], target_x_i} - {measured_x_i[19], measured_x_i};
    dy  = {target_y_i[19], target_y_i} - {measured_y_i[19], measured_y_i};
    dth = $signed({target_heading_i[14], target_heading_i} -
                  {measured_heading_i[14], measured_heading_i});
    if (dth < -$signed(hgpc_pkg::HALF_TURN)) begin
      dthw = dth + $signed(hgpc_pkg::FULL_TURN);
    end else if (dth > $signed(hgpc_pkg::HALF_TURN)) begin
      dthw = dth - $signed(hgpc_pkg::FULL_TURN);
    end else begin
      dthw = dth;
    end
    hmag = dthw[15] ? 16'(-dthw) : 16'(dthw);

    ang = measured_heading_i[14] ? measured_heading_i + hgpc_pkg::TURN_15
                                 : measured_heading_i;
    if (ang >= 15'd17280) begin
      quad = 2'd3;
      rem  = ang - 15'd17280;
    end else if (ang >= 15'd11520) begin
      quad = 2'd2;
      rem  = ang - 15'd11520;
    end else if (ang >= hgpc_pkg::QUARTER) begin
      quad = 2'd1;
      rem  = ang - hgpc_pkg::QUARTER;
    end else begin
      quad = 2'd0;
      rem  = ang;
    end

    f_d.ex.neg  = dx[20];
    f_d.ex.mag  = dx[20] ? -dx : dx;
    f_d.ex.dead = f_d.ex.mag < {10'd0, cfg_i.pos_tol};
    f_d.ey.neg  = dy[20];
    f_d.ey.mag  = dy[20] ? -dy : dy;
    f_d.ey.dead = f_d.ey.mag < {10'd0, cfg_i.pos_tol};
    f_d.eh.neg  = dthw[15];
    f_d.eh.mag  = hmag[13:0];
    f_d.eh.dead = hmag < {2'd0, cfg_i.head_tol};
    f_d.swap    = rem > hgpc_pkg::EIGHTH;
    f_d.oct     = f_d.swap ? 12'(hgpc_pkg::QUARTER - rem) : rem[11:0];
    f_d.quad    = quad;

    f_v_d = accept ? 1'b1 : (push_o ? 1'b0 : f_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= f_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q <= f_d;
    end
  end

endmodule

@@ rtl/hgpc_queue.sv @@
// ----------------------------------------------------------------------------
// hgpc_queue
// Four-entry queue between the front and the back datapath.
// ----------------------------------------------------------------------------
module hgpc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hgpc_pkg::item_t   item_i,
  input  logic              pop_i,
  output hgpc_pkg::item_t   item_o,
  output hgpc_pkg::q_stat_t stat_o
);

  hgpc_pkg::item_t ent_q [4];
  logic [1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [2:0]      cnt_q, cnt_d;

  assign stat_o.full  = cnt_q == 3'd4;
  assign stat_o.empty = cnt_q == 3'd0;
  assign item_o       = ent_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + 2'd1 : wp_q;
    rp_d  = pop_i ? rp_q + 2'd1 : rp_q;
    cnt_d = cnt_q + {2'd0, push_i} - {2'd0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= item_i;
    end
  end

endmodule

@@ rtl/hgpc_sincos.sv @@
// ----------------------------------------------------------------------------
// hgpc_sincos
// Twelve-stage Q30 sine and cosine from an octant angle and its quadrant.
// ----------------------------------------------------------------------------
module hgpc_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [11:0]        oct_i,
  input  logic               swap_i,
  input  logic [1:0]         quad_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic [29:0] x_q  [1:10];
  logic [29:0] x2_q [2:10];
  logic [2:0]  sq_q [1:11];

  logic [31:0] qs_q, qc_q;
  logic [30:0] ts_q, tc_q;
  logic [29:0] ps_q, pc_q;
  logic [31:0] qs2_q, qc2_q;
  logic [30:0] ts2_q, tc2_q;
  logic [29:0] ps2_q, pc2_q;
  logic [29:0] ps3_q, pc3_q;
  logic [29:0] ps4_q, pc4_q;
  logic [31:0] qs3_q, qc3_q;
  logic [30:0] ts3_q, tc3_q;
  logic [30:0] s11_q;
  logic [29:0] pc11_q;

  logic [59:0] x_sq;
  logic [63:0] m_s3, m_c3, m_s5, m_c5, m_s6, m_c6, m_s8, m_c8, m_s9, m_c9, m_s11, m_c11;
  logic [30:0] s_un, c_un, s_sel, c_sel;

  always_comb begin
    x_sq  = 60'(x_q[1]) * 60'(x_q[1]);
    m_s3  = 64'(x2_q[2]) * 64'(hgpc_pkg::RCP_42);
    m_c3  = 64'(x2_q[2]) * 64'(hgpc_pkg::RCP_56);
    m_s5  = 64'(x2_q[4]) * 64'(ts_q);
    m_c5  = 64'(x2_q[4]) * 64'(tc_q);
    m_s6  = 64'(ps_q) * 64'(hgpc_pkg::RCP_20);
    m_c6  = 64'(pc_q) * 64'(hgpc_pkg::RCP_30);
    m_s8  = 64'(x2_q[7]) * 64'(ts2_q);
    m_c8  = 64'(x2_q[7]) * 64'(tc2_q);
    m_s9  = 64'(ps3_q) * 64'(hgpc_pkg::RCP_6);
    m_c9  = 64'(pc3_q) * 64'(hgpc_pkg::RCP_12);
    m_s11 = 64'(x_q[10]) * 64'(ts3_q);
    m_c11 = 64'(x2_q[10]) * 64'(tc3_q);

    c_un = hgpc_pkg::Q30_ONE - 31'(pc11_q >> 1);
    s_un = s11_q;
    s_sel = sq_q[11][2] ? c_un : s_un;
    c_sel = sq_q[11][2] ? s_un : c_un;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[1]  <= 30'(30'(oct_i) * 30'(hgpc_pkg::RAD_PER_U));
      sq_q[1] <= {swap_i, quad_i};
      for (int k = 2; k <= 10; k++) begin
        x_q[k] <= x_q[k-1];
      end
      for (int k = 2; k <= 11; k++) begin
        sq_q[k] <= sq_q[k-1];
      end
      x2_q[2] <= x_sq[59:30];
      for (int k = 3; k <= 10; k++) begin
        x2_q[k] <= x2_q[k-1];
      end
      // Innermost terms: 1 - x^2/42 for sine, 1 - x^2/56 for cosine.
      qs_q  <= {2'd0, m_s3[61:32]};
      qc_q  <= {2'd0, m_c3[61:32]};
      ts_q  <= hgpc_pkg::Q30_ONE - 31'(hgpc_pkg::quot_fix({2'd0, x2_q[3]}, qs_q, 6'd42));
      tc_q  <= hgpc_pkg::Q30_ONE - 31'(hgpc_pkg::quot_fix({2'd0, x2_q[3]}, qc_q, 6'd56));
      ps_q  <= m_s5[59:30];
      pc_q  <= m_c5[59:30];
      ps2_q <= ps_q;
      pc2_q <= pc_q;
      qs2_q <= {2'd0, m_s6[61:32]};
      qc2_q <= {2'd0, m_c6[61:32]};
      ts2_q <= hgpc_pkg::Q30_ONE - 31'(hgpc_pkg::quot_fix({2'd0, ps2_q}, qs2_q, 6'd20));
      tc2_q <= hgpc_pkg::Q30_ONE - 31'(hgpc_pkg::quot_fix({2'd0, pc2_q}, qc2_q, 6'd30));
    end
  end

  // Stages eight to twelve keep their own block for readability.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps3_q  <= m_s8[59:30];
      pc3_q  <= m_c8[59:30];
      ps4_q  <= ps3_q;
      pc4_q  <= pc3_q;
      qs3_q  <= {2'd0, m_s9[61:32]};
      qc3_q  <= {2'd0, m_c9[61:32]};
      ts3_q  <= hgpc_pkg::Q30_ONE - 31'(hgpc_pkg::quot_fix({2'd0, ps4_q}, qs3_q, 6'd6));
      tc3_q  <= hgpc_pkg::Q30_ONE - 31'(hgpc_pkg::quot_fix({2'd0, pc4_q}, qc3_q, 6'd12));
      s11_q  <= m_s11[60:30];
      pc11_q <= m_c11[59:30];
      case (sq_q[11][1:0])
        2'd0: begin
          sin_o <= $signed({1'b0, s_sel});
          cos_o <= $signed({1'b0, c_sel});
        end
        2'd1: begin
          sin_o <= $signed({1'b0, c_sel});
          cos_o <= -$signed({1'b0, s_sel});
        end
        2'd2: begin
          sin_o <= -$signed({1'b0, s_sel});
          cos_o <= -$signed({1'b0, c_sel});
        end
        default: begin
          sin_o <= -$signed({1'b0, c_sel});
          cos_o <= $signed({1'b0, s_sel});
        end
      endcase
    end
  end

endmodule

@@ rtl/hgpc_back.sv @@
// ----------------------------------------------------------------------------
// hgpc_back
// Fifteen-stage datapath: scaled and clamped commands, rotation, rounding.
// ----------------------------------------------------------------------------
module hgpc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hgpc_pkg::cfg_t    cfg_i,
  input  hgpc_pkg::item_t   item_i,
  input  logic              item_valid_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [16:0]       local_vx_o,
  output logic [16:0]       local_vy_o,
  output logic [15:0]       turn_rate_o,
  output logic              at_goal_o
);

  typedef struct packed {
    logic xn, xd, yn, yd, hn, hd;
  } flags_t;

  typedef struct packed {
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] gth;
  } gcmd_t;

  logic [15:1] v_q;
  logic        en;

  logic [35:0] px1_q, py1_q;
  logic [28:0] ph1_q;
  flags_t      fl1_q, fl2_q, fl3_q;
  logic [31:0] vx2_q, vy2_q, vh2_q, vx3_q, vy3_q, vh3_q;
  logic [31:0] qx3_q, qy3_q, qh3_q;
  gcmd_t       g_q [4:14];

  logic signed [31:0] sin_w, cos_w;
  logic signed [47:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [48:0] sx_q, sy_q;

  logic [63:0] mx, my, mh;
  gcmd_t       g_d;
  logic [48:0] ax, ay;
  logic [18:0] rx, ry;
  logic [16:0] lx_d, ly_d;

  assign en          = !(v_q[15] && out_stall_i);
  assign pop_o       = en && item_valid_i;
  assign out_valid_o = v_q[15];

  function automatic logic [15:0] finish(input logic [31:0] v, input logic [31:0] q0,
                                         input logic [14:0] lim, input logic neg,
                                         input logic dead);
    logic [31:0] q;
    logic [14:0] m;
    q = hgpc_pkg::quot_fix(v, q0, 6'd15);
    m = (q > {17'd0, lim}) ? lim : q[14:0];
    if (dead) begin
      return 16'd0;
    end
    return neg ? -{1'b0, m} : {1'b0, m};
  endfunction

  always_comb begin
    mx = 64'(vx2_q) * 64'(hgpc_pkg::RCP_15);
    my = 64'(vy2_q) * 64'(hgpc_pkg::RCP_15);
    mh = 64'(vh2_q) * 64'(hgpc_pkg::RCP_15);
    g_d.gx  = finish(vx3_q, qx3_q, cfg_i.max_lin, fl3_q.xn, fl3_q.xd);
    g_d.gy  = finish(vy3_q, qy3_q, cfg_i.max_lin, fl3_q.yn, fl3_q.yd);
    g_d.gth = finish(vh3_q, qh3_q, cfg_i.max_turn, fl3_q.hn, fl3_q.hd);
    // Round half away from zero on the magnitude of the Q30 sums.
    ax   = sx_q[48] ? 49'(-sx_q) : 49'(sx_q);
    ay   = sy_q[48] ? 49'(-sy_q) : 49'(sy_q);
    rx   = 19'((ax + 49'h2000_0000) >> 30);
    ry   = 19'((ay + 49'h2000_0000) >> 30);
    lx_d = sx_q[48] ? -rx[16:0] : rx[16:0];
    ly_d = sy_q[48] ? -ry[16:0] : ry[16:0];
  end

  hgpc_sincos u_sincos (
    .clk_i  (clk_i),
    .en_i   (en),
    .oct_i  (item_i.oct),
    .swap_i (item_i.swap),
    .quad_i (item_i.quad),
    .sin_o  (sin_w),
    .cos_o  (cos_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[14:1], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= 36'(item_i.ex.mag) * 36'(cfg_i.max_lin);
      py1_q <= 36'(item_i.ey.mag) * 36'(cfg_i.max_lin);
      ph1_q <= 29'(item_i.eh.mag) * 29'(cfg_i.max_turn);
      fl1_q <= '{item_i.ex.neg, item_i.ex.dead, item_i.ey.neg, item_i.ey.dead,
                 item_i.eh.neg, item_i.eh.dead};
      // Divide by 240 as a shift by 4 then a divide by 15; by 960 as a shift by 6 then 15.
      vx2_q <= 32'((px1_q + 36'd120) >> 4);
      vy2_q <= 32'((py1_q + 36'd120) >> 4);
      vh2_q <= 32'((ph1_q + 29'd480) >> 6);
      fl2_q <= fl1_q;
      qx3_q <= mx[63:32];
      qy3_q <= my[63:32];
      qh3_q <= mh[63:32];
      vx3_q <= vx2_q;
      vy3_q <= vy2_q;
      vh3_q <= vh2_q;
      fl3_q <= fl2_q;
      g_q[4] <= g_d;
      for (int k = 5; k <= 14; k++) begin
        g_q[k] <= g_q[k-1];
      end
      pxc_q <= $signed(g_q[12].gx) * cos_w;
      pys_q <= $signed(g_q[12].gy) * sin_w;
      pyc_q <= $signed(g_q[12].gy) * cos_w;
      pxs_q <= $signed(g_q[12].gx) * sin_w;
      sx_q  <= 49'(pxc_q) + 49'(pys_q);
      sy_q  <= 49'(pyc_q) - 49'(pxs_q);
      local_vx_o  <= lx_d;
      local_vy_o  <= ly_d;
      turn_rate_o <= g_q[14].gth;
      at_goal_o   <= (lx_d == 17'd0) && (ly_d == 17'd0) && (g_q[14].gth == 16'd0);
    end
  end

endmodule

@@ rtl/holonomic_goal_p_controller.sv @@
// ----------------------------------------------------------------------------
// holonomic_goal_p_controller
// Saturated proportional pose controller with rotation into the robot frame.
// ----------------------------------------------------------------------------
// An accepted pose pair passes one front stage, one queue slot and fifteen back
// stages with the sine/cosine pipe before its result is valid.
// Throughput: one pose pair per cycle unless in_stall_o is raised; the front register
// and a four-entry queue let the input keep flowing while a result waits.
// Reset: pipeline and queue empty; the four registers take 16, 64, 2560, 2048.
module holonomic_goal_p_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] target_x_i,
  input  logic [19:0] target_y_i,
  input  logic [14:0] target_heading_i,
  input  logic [19:0] measured_x_i,
  input  logic [19:0] measured_y_i,
  input  logic [14:0] measured_heading_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] local_vx_o,
  output logic [16:0] local_vy_o,
  output logic [15:0] turn_rate_o,
  output logic        at_goal_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hgpc_pkg::cfg_t     cfg_q;
  hgpc_pkg::reg_idx_e ridx;
  hgpc_pkg::item_t    f_item, q_item;
  hgpc_pkg::q_stat_t  q_stat;
  logic               push, pop;

  assign pready = 1'b1;
  assign ridx   = hgpc_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (ridx)
      hgpc_pkg::REG_POS_TOL:  prdata = {21'd0, cfg_q.pos_tol};
      hgpc_pkg::REG_HEAD_TOL: prdata = {18'd0, cfg_q.head_tol};
      hgpc_pkg::REG_MAX_LIN:  prdata = {17'd0, cfg_q.max_lin};
      hgpc_pkg::REG_MAX_TURN: prdata = {17'd0, cfg_q.max_turn};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_tol  <= 11'd16;
      cfg_q.head_tol <= 14'd64;
      cfg_q.max_lin  <= 15'd2560;
      cfg_q.max_turn <= 15'd2048;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        hgpc_pkg::REG_POS_TOL:  cfg_q.pos_tol  <= pwdata[10:0];
        hgpc_pkg::REG_HEAD_TOL: cfg_q.head_tol <= pwdata[13:0];
        hgpc_pkg::REG_MAX_LIN:  cfg_q.max_lin  <= pwdata[14:0];
        hgpc_pkg::REG_MAX_TURN: cfg_q.max_turn <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  hgpc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (in_valid_i),
    .stall_o            (in_stall_o),
    .target_x_i         (target_x_i),
    .target_y_i         (target_y_i),
    .target_heading_i   (target_heading_i),
    .measured_x_i       (measured_x_i),
    .measured_y_i       (measured_y_i),
    .measured_heading_i (measured_heading_i),
    .cfg_i              (cfg_q),
    .q_stat_i           (q_stat),
    .push_o             (push),
    .item_o             (f_item)
  );

  hgpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  hgpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (q_item),
    .item_valid_i (!q_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .local_vx_o   (local_vx_o),
    .local_vy_o   (local_vy_o),
    .turn_rate_o  (turn_rate_o),
    .at_goal_o    (at_goal_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("queue read while empty");

  a_goal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && at_goal_o) |->
      (local_vx_o == 17'd0 && local_vy_o == 17'd0 && turn_rate_o == 16'd0))
    else $error("at_goal set with a nonzero command");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Holonomic goal P controller testbench
// Drives pose pairs through the controller with random gaps and stalls,
// predicts each velocity command from its own integer model of the control
// law and compares every transaction field by field. Configuration is
// written over the register port between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 17;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint Q30 = 64'sd1 << 30;

  typedef struct {
    logic [19:0] tx;
    logic [19:0] ty;
    logic [14:0] th;
    logic [19:0] mx;
    logic [19:0] my;
    logic [14:0] mh;
  } pose_pair_t;

  typedef struct {
    logic [16:0] vx;
    logic [16:0] vy;
    logic [15:0] wz;
    logic        at_goal;
  } command_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [19:0] target_x_i = '0;
  logic [19:0] target_y_i = '0;
  logic [14:0] target_heading_i = '0;
  logic [19:0] measured_x_i = '0;
  logic [19:0] measured_y_i = '0;
  logic [14:0] measured_heading_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [16:0] local_vx_o;
  logic [16:0] local_vy_o;
  logic [15:0] turn_rate_o;
  logic        at_goal_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  holonomic_goal_p_controller i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Controller settings as the predictor sees them.
  longint pos_tol, head_tol, lin_max, turn_max;

  pose_pair_t pending_poses[$];
  command_t   expected_cmds[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  int  gap_left = 0;
  int  stall_left = 0;

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_div(longint p, longint d);
    longint q;
    q = (abs64(p) + d / 2) / d;
    return p < 0 ? -q : q;
  endfunction

  function automatic longint p_term(longint err, longint lim, longint div, longint tol);
    longint v;
    if (abs64(err) < tol) return 0;
    v = round_div(err * lim, div);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Taylor sine/cosine of 0..45 degrees in Q30, truncating as the datapath does.
  function automatic void octant_trig(input longint u, output longint s, output longint c);
    longint unsigned x, x2, t;
    x = u * 292818;
    x2 = (x * x) >> 30;
    t = Q30 - x2 / 42;
    t = Q30 - ((x2 * t) >> 30) / 20;
    t = Q30 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    t = Q30 - x2 / 56;
    t = Q30 - ((x2 * t) >> 30) / 30;
    t = Q30 - ((x2 * t) >> 30) / 12;
    c = Q30 - ((x2 * t) >> 30) / 2;
  endfunction

  function automatic command_t predict_command(pose_pair_t p);
    longint dx, dy, dth, gx, gy, gth, a, q, r, s0, c0, s, c, lx, ly;
    command_t cmd;
    dx = longint'($signed(p.tx)) - longint'($signed(p.mx));
    dy = longint'($signed(p.ty)) - longint'($signed(p.my));
    dth = longint'($signed(p.th)) - longint'($signed(p.mh));
    if (dth < -11520) dth += 23040;
    else if (dth > 11520) dth -= 23040;
    gx = p_term(dx, lin_max, 240, pos_tol);
    gy = p_term(dy, lin_max, 240, pos_tol);
    gth = p_term(dth, turn_max, 960, head_tol);
    a = longint'($signed(p.mh)) % 23040;
    if (a < 0) a += 23040;
    q = a / 5760;
    r = a % 5760;
    if (r <= 2880) octant_trig(r, s0, c0);
    else octant_trig(5760 - r, c0, s0);
    case (q)
      0: begin s = s0; c = c0; end
      1: begin s = c0; c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
    lx = round_div(gx * c + gy * s, Q30);
    ly = round_div(gy * c - gx * s, Q30);
    cmd.vx = lx[16:0];
    cmd.vy = ly[16:0];
    cmd.wz = gth[15:0];
    cmd.at_goal = (lx == 0 && ly == 0 && gth == 0);
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic int random_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Driver: presents queued poses, holds the payload while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_cmds.push_back(predict_command(pending_poses.pop_front()));
        gap_left = random_gap();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_poses.size() > 0) begin
          in_valid_i <= 1'b1;
          target_x_i <= pending_poses[0].tx;
          target_y_i <= pending_poses[0].ty;
          target_heading_i <= pending_poses[0].th;
          measured_x_i <= pending_poses[0].mx;
          measured_y_i <= pending_poses[0].my;
          measured_heading_i <= pending_poses[0].mh;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and sets the receiver stall.
  always @(posedge clk_i) begin
    command_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          error_count++;
          $display("%0t: result with no pose pair outstanding", $realtime);
        end else begin
          want = expected_cmds.pop_front();
          if (local_vx_o !== want.vx)
            report_mismatch("local_vx", $signed(local_vx_o), $signed(want.vx));
          if (local_vy_o !== want.vy)
            report_mismatch("local_vy", $signed(local_vy_o), $signed(want.vy));
          if (turn_rate_o !== want.wz)
            report_mismatch("turn_rate", $signed(turn_rate_o), $signed(want.wz));
          if (at_goal_o !== want.at_goal)
            report_mismatch("at_goal", at_goal_o, want.at_goal);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = random_gap();
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pending_poses.size() == 0 && expected_cmds.size() == 0) || (hold_left > 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_register(input hgpc_pkg::reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      hgpc_pkg::REG_POS_TOL:  pos_tol = value & 32'h7FF;
      hgpc_pkg::REG_HEAD_TOL: head_tol = value & 32'h3FFF;
      hgpc_pkg::REG_MAX_LIN:  lin_max = value & 32'h7FFF;
      default:                turn_max = value & 32'h7FFF;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_poses.size() > 0 || expected_cmds.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  task automatic add_pose(input logic [19:0] tx, ty, mx, my, input logic [14:0] th, mh);
    pose_pair_t p;
    p.tx = tx; p.ty = ty; p.th = th; p.mx = mx; p.my = my; p.mh = mh;
    pending_poses.push_back(p);
  endtask

  function automatic logic [14:0] random_heading();
    if ($urandom_range(0, 9) == 0) return 15'($urandom);
    return 15'($urandom_range(0, 23040) - 11520);
  endfunction

  // Mostly positions near each other so the deadband and the ramp are hit.
  task automatic add_random_pose();
    logic [19:0] mx, my;
    logic [14:0] mh;
    mx = 20'($urandom);
    my = 20'($urandom);
    mh = random_heading();
    case ($urandom_range(0, 3))
      0: add_pose(20'($urandom), 20'($urandom), mx, my, random_heading(), mh);
      1: add_pose(mx + 20'($urandom_range(0, 80) - 40), my + 20'($urandom_range(0, 80) - 40),
                  mx, my, mh + 15'($urandom_range(0, 200) - 100), mh);
      default: add_pose(mx + 20'($urandom_range(0, 8000) - 4000),
                        my + 20'($urandom_range(0, 8000) - 4000), mx, my,
                        random_heading(), mh);
    endcase
  endtask

  task automatic random_config();
    write_register(hgpc_pkg::REG_POS_TOL, $urandom_range(0, 1600));
    write_register(hgpc_pkg::REG_HEAD_TOL, $urandom_range(0, 11520));
    write_register(hgpc_pkg::REG_MAX_LIN, $urandom_range(0, 25600));
    write_register(hgpc_pkg::REG_MAX_TURN, $urandom_range(0, 16384));
  endtask

  initial begin
    pos_tol = 16;
    head_tol = 64;
    lin_max = 2560;
    turn_max = 2048;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, heading wrap edges and the zero-error case.
    add_pose(20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 15'd11520, -15'sd11520);
    add_pose(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, -15'sd11520, 15'd11520);
    add_pose(20'd100, 20'd200, 20'd100, 20'd200, 15'd300, 15'd300);
    add_pose(20'd1000, 20'd0, 20'd0, 20'd0, 15'd11520, 15'd0);
    add_pose(20'd0, 20'd1000, 20'd0, 20'd0, -15'sd11520, 15'd0);
    add_pose(20'd15, -20'sd15, 20'd0, 20'd0, 15'd63, 15'd0);
    add_pose(20'd16, -20'sd16, 20'd0, 20'd0, -15'sd64, 15'd0);
    add_pose(20'd500, 20'd500, 20'd0, 20'd0, 15'd10000, -15'sd10000);
    add_pose(20'd500, -20'sd500, 20'd0, 20'd0, -15'sd10000, 15'd10000);
    add_pose(20'd240, 20'd0, 20'd0, 20'd0, 15'd0, 15'd5760);
    add_pose(20'd240, 20'd0, 20'd0, 20'd0, 15'd0, 15'd2880);
    add_pose(20'd240, 20'd0, 20'd0, 20'd0, 15'd0, -15'sd5760);
    add_pose(20'd240, 20'd0, 20'd0, 20'd0, 15'd0, 15'h7FFF);
    add_pose(20'd240, 20'd0, 20'd0, 20'd0, 15'd0, 15'h4000);
    wait_drained();

    // Zero tolerances and full-scale limits.
    write_register(hgpc_pkg::REG_POS_TOL, 32'd0);
    write_register(hgpc_pkg::REG_HEAD_TOL, 32'd0);
    write_register(hgpc_pkg::REG_MAX_LIN, 32'h7FFF);
    write_register(hgpc_pkg::REG_MAX_TURN, 32'h7FFF);
    add_pose(20'd1, 20'd0, 20'd0, 20'd0, 15'd1, 15'd0);
    add_pose(20'h7FFFF, 20'h80000, 20'h80000, 20'h7FFFF, 15'h3FFF, 15'h4000);
    add_pose(20'd3, -20'sd7, 20'd0, 20'd0, -15'sd1, 15'd700);
    wait_drained();

    // Zero limits, widest deadbands and a value wider than its register.
    write_register(hgpc_pkg::REG_POS_TOL, 32'hFFFF_FFFF);
    write_register(hgpc_pkg::REG_HEAD_TOL, 32'd11520);
    write_register(hgpc_pkg::REG_MAX_LIN, 32'd0);
    write_register(hgpc_pkg::REG_MAX_TURN, 32'd0);
    add_pose(20'd5000, 20'd5000, 20'd0, 20'd0, 15'd11520, 15'd0);
    add_pose(20'd100, 20'd100, 20'd0, 20'd0, 15'd100, 15'd0);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_register(hgpc_pkg::REG_POS_TOL, 32'd16);
        write_register(hgpc_pkg::REG_HEAD_TOL, 32'd64);
        write_register(hgpc_pkg::REG_MAX_LIN, 32'd25600);
        write_register(hgpc_pkg::REG_MAX_TURN, 32'd16384);
      end else begin
        random_config();
      end
      for (int n = 0; n < 190; n++) add_random_pose();
      // Hold off the receiver so the pipeline fills and stalls its input.
      if (phase == 2) begin
        hold_left = 300;
      end
      wait_drained();
    end

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
